### hdl/cplr_pkg.sv
// Package for the CRC packet link receiver: sizes, codes and types.
// Used by every module in hdl; depends on nothing.
`default_nettype none
package cplr_pkg;
  localparam int DataBytes   = 16;
  localparam int QueueSlots  = 8;
  localparam int PktLen      = DataBytes + 2;
  localparam int PosW        = $clog2(PktLen + 1);
  localparam int SlotW       = $clog2(QueueSlots);
  localparam int QDepth      = QueueSlots * PktLen;
  localparam int QAddrW      = $clog2(QDepth);
  localparam int RxW         = $clog2(DataBytes + 1);

  localparam logic [1:0] CMD_LINK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_SEND = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [1:0] REG_POLY = 2'd0;
  localparam logic [1:0] REG_INIT = 2'd1;
  localparam logic [1:0] REG_RETX = 2'd2;
  localparam logic [1:0] REG_ACK  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_BUILD, ST_EMIT, ST_WAIT
  } state_e;

  // Burst sources for the emit sequencer.
  typedef enum logic [1:0] {
    SRC_LAST, SRC_QUEUE, SRC_SINGLE
  } src_e;

  typedef struct packed {
    logic       load;       // latch the request
    logic       exec;       // perform the immediate part of the request
    logic       build;      // advance the single-packet CRC build
    logic       emit;       // present burst byte at pos
    logic       step;       // advance burst position
    src_e       src;
  } ctl_t;

  typedef struct packed {
    logic       burst;      // request needs an 18-byte burst
    src_e       src;
    logic       single_out; // request gives one result byte
    logic       build_done;
    logic       emit_last;
  } sts_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction
endpackage
`default_nettype wire

### hdl/cplr_ctrl.sv
// Controller state machine for the CRC packet link receiver.
// Depends on cplr_pkg; drives cplr_dp by command struct.
`default_nettype none
module cplr_ctrl import cplr_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  wire  out_ready_i,
  input  wire  out_full_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);
  state_e state_q, state_d;
  src_e   src_q, src_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      src_q   <= SRC_LAST;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    src_d      = src_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    ctl_o.src  = src_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // every request waits for the output register to be free; single results need it
        if (!out_full_i || out_ready_i) begin
          ctl_o.exec = 1'b1;
          src_d      = sts_i.src;
          if (!sts_i.burst) state_d = ST_IDLE;
          else if (sts_i.src == SRC_SINGLE) state_d = ST_BUILD;
          else state_d = ST_EMIT;
        end
      end
      ST_BUILD: begin
        ctl_o.build = 1'b1;
        if (sts_i.build_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_full_i || out_ready_i) begin
          ctl_o.emit = 1'b1;
          ctl_o.step = 1'b1;
          if (sts_i.emit_last) state_d = ST_IDLE;
        end
      end
      ST_WAIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.emit |-> !(out_full_i && !out_ready_i))
    else $error("emit into full output register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> state_q == ST_EXEC)
    else $error("load did not start execution");
endmodule
`default_nettype wire

### hdl/cplr_dp.sv
// Datapath for the CRC packet link receiver: receive state, queue memory,
// last-sent buffer and output register. Depends on cplr_pkg.
`default_nettype none
module cplr_dp import cplr_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [1:0] cfg_idx_i,
  input  wire  [7:0] cfg_data_i,
  input  wire  [1:0] cmd_i,
  input  wire  [7:0] data_byte_i,
  input  wire        host_last_i,
  input  ctl_t       ctl_i,
  output sts_t       sts_o,
  output logic       out_full_o,
  input  wire        out_ready_i,
  output logic       dest_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       read_empty_o,
  output logic       packets_waiting_o
);
  logic [7:0] poly_q, init_q, retx_q, ack_q;
  logic [1:0] cmd_q;
  logic [7:0] b_q;
  logic       hl_q;
  logic [1:0] phase_q;
  logic [RxW-1:0] cnt_q;
  logic [7:0] rx_q [DataBytes+1];
  logic [7:0] crc_q;
  logic [7:0] last_q [PktLen];
  logic [SlotW-1:0] rd_q, wr_q;
  logic [SlotW-1:0] wslot_q;
  logic [PosW-1:0] htx_q;
  logic [PosW-1:0] pos_q;
  logic [7:0] bcrc_q;
  logic [7:0] qmem [QDepth];
  logic [7:0] qrd_q;
  logic       full_q;
  logic       dest_q, lastr_q, empty_q, wait_q;
  logic [7:0] obyte_q;

  // Packet classification on the held request.
  function automatic logic is_single(input logic [7:0] code, input logic [7:0] rx [DataBytes+1]);
    logic ok;
    ok = (rx[0] == 8'd1) && (rx[1] == code);
    for (int i = 2; i <= DataBytes; i++) ok = ok && (rx[i] == 8'hff);
    return ok;
  endfunction

  logic is_link_end, crc_bad, is_retx, is_ack, q_full, q_empty;
  logic [SlotW-1:0] wr_nxt, rd_nxt;
  assign wr_nxt = (wr_q == SlotW'(QueueSlots - 1)) ? '0 : wr_q + 1'b1;
  assign rd_nxt = (rd_q == SlotW'(QueueSlots - 1)) ? '0 : rd_q + 1'b1;
  assign q_full  = (wr_nxt == rd_q);
  assign q_empty = (rd_q == wr_q);
  assign is_link_end = (cmd_q == CMD_LINK) && (phase_q == 2'd2);
  assign crc_bad = (b_q != crc_q);
  assign is_retx = is_single(retx_q, rx_q);
  assign is_ack  = is_single(ack_q, rx_q);

  always_comb begin
    sts_o = '0;
    sts_o.src = SRC_LAST;
    if (is_link_end) begin
      if (crc_bad) begin
        sts_o.burst = 1'b1; sts_o.src = SRC_SINGLE;
      end else if (is_retx) begin
        sts_o.burst = 1'b1; sts_o.src = SRC_LAST;
      end else if (!is_ack) begin
        sts_o.burst = 1'b1; sts_o.src = SRC_SINGLE;
      end
    end else if (cmd_q == CMD_READ) begin
      if (!q_empty) begin
        sts_o.burst = 1'b1; sts_o.src = SRC_QUEUE;
      end else begin
        sts_o.single_out = 1'b1;
      end
    end else if (cmd_q == CMD_SEND) begin
      sts_o.single_out = 1'b1;
    end
    sts_o.build_done = (pos_q == PosW'(PktLen - 2));
    sts_o.emit_last  = (pos_q == PosW'(PktLen - 1));
  end

  // Hold the request and the queue slot being filled.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      b_q   <= data_byte_i;
      hl_q  <= host_last_i;
    end
    if (ctl_i.exec) wslot_q <= wr_q;
  end

  logic [7:0] code_q;
  logic [SlotW-1:0] qslot_q;
  logic [7:0] sbyte;
  logic [QAddrW-1:0] qwaddr, qraddr;
  logic qwe;
  logic [7:0] qwdata;
  logic [7:0] build_b;
  assign sbyte   = (pos_q == PosW'(0)) ? 8'd1 : (pos_q == PosW'(1)) ? code_q : 8'hff;
  assign build_b = sbyte;

  // Queue write copies the accepted packet one byte per cycle in the
  // ack build, its CRC byte at the last emit; pos_q indexes the byte.
  logic copy_q;
  always_comb begin
    qwe    = 1'b0;
    qwdata = 8'h00;
    qwaddr = QAddrW'(wslot_q) * QAddrW'(PktLen) + QAddrW'(pos_q);
    if (copy_q && ctl_i.build) begin
      qwe    = 1'b1;
      qwdata = rx_q[pos_q[RxW-1:0]];
    end else if (copy_q && ctl_i.emit && pos_q == PosW'(PktLen - 1)) begin
      qwe    = 1'b1;
      qwdata = b_q;
    end
  end
  // Read address runs one ahead so registered data lines up with pos.
  logic [PosW-1:0] pos_rd;
  logic [SlotW-1:0] rslot;
  assign pos_rd = (ctl_i.exec) ? '0 : pos_q + PosW'(ctl_i.step);
  assign rslot  = (ctl_i.exec) ? rd_q : qslot_q;
  assign qraddr = QAddrW'(rslot) * QAddrW'(PktLen) + QAddrW'(pos_rd);

  always_ff @(posedge clk_i) begin
    if (qwe) qmem[qwaddr] <= qwdata;
    qrd_q <= qmem[qraddr];
  end

  logic [7:0] emit_b;
  always_comb begin
    case (ctl_i.src)
      SRC_QUEUE:  emit_b = qrd_q;
      SRC_SINGLE: emit_b = last_q[pos_q[PosW-1:0] < PosW'(PktLen) ? pos_q : '0];
      default:    emit_b = last_q[pos_q < PosW'(PktLen) ? pos_q : '0];
    endcase
  end

  // Requests that put a new byte into the output register.
  logic out_load;
  assign out_load = ctl_i.emit ||
                    (ctl_i.exec && (cmd_q == CMD_READ || cmd_q == CMD_SEND));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= 8'd7; init_q <= 8'd0; retx_q <= 8'd25; ack_q <= 8'd21;
      phase_q <= 2'd0; cnt_q <= '0; crc_q <= 8'd0;
      for (int i = 0; i < PktLen; i++) last_q[i] <= 8'd0;
      rd_q <= '0; wr_q <= '0; htx_q <= '0; pos_q <= '0;
      full_q <= 1'b0; copy_q <= 1'b0; wait_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POLY: poly_q <= cfg_data_i;
          REG_INIT: init_q <= cfg_data_i;
          REG_RETX: retx_q <= cfg_data_i;
          REG_ACK:  ack_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (full_q && out_ready_i && !out_load) full_q <= 1'b0;
      if (ctl_i.exec) begin
        pos_q  <= '0;
        copy_q <= is_link_end && !crc_bad && !is_retx && !is_ack && !q_full;
        case (cmd_q)
          CMD_LINK: begin
            if (phase_q == 2'd1) begin
              rx_q[RxW'(1) + cnt_q] <= b_q;
              crc_q <= crc_byte(crc_q, b_q, poly_q);
              if (cnt_q == RxW'(DataBytes - 1)) begin
                cnt_q <= '0; phase_q <= 2'd2;
              end else cnt_q <= cnt_q + 1'b1;
            end else if (phase_q == 2'd2) begin
              phase_q <= 2'd0;
              bcrc_q  <= init_q;
              if (crc_bad) code_q <= retx_q;
              else if (!is_retx && !is_ack) begin
                code_q <= ack_q;
                if (!q_full) wr_q <= wr_nxt;
              end
            end else if (b_q <= 8'(DataBytes)) begin
              rx_q[0] <= b_q;
              crc_q   <= crc_byte(init_q, b_q, poly_q);
              cnt_q   <= '0;
              phase_q <= 2'd1;
            end
          end
          CMD_READ: begin
            full_q <= q_empty; dest_q <= 1'b1; lastr_q <= 1'b1;
            obyte_q <= 8'd0; empty_q <= 1'b1; wait_q <= !q_empty;
            if (!q_empty) begin
              qslot_q <= rd_q;
              rd_q    <= rd_nxt;
            end
          end
          CMD_SEND: begin
            last_q[htx_q] <= b_q;
            htx_q <= (hl_q || htx_q == PosW'(PktLen - 1)) ? '0 : htx_q + 1'b1;
            full_q <= 1'b1; dest_q <= 1'b0; obyte_q <= b_q;
            lastr_q <= 1'b1; empty_q <= 1'b0; wait_q <= !q_empty;
          end
          default: ;
        endcase
      end
      if (ctl_i.build) begin
        last_q[pos_q] <= build_b;
        bcrc_q <= crc_byte(bcrc_q, build_b, poly_q);
        if (pos_q == PosW'(PktLen - 2)) begin
          last_q[PktLen-1] <= crc_byte(bcrc_q, build_b, poly_q);
          pos_q <= '0;
        end else pos_q <= pos_q + 1'b1;
      end
      if (ctl_i.emit) begin
        full_q  <= 1'b1;
        dest_q  <= (ctl_i.src == SRC_QUEUE);
        obyte_q <= emit_b;
        lastr_q <= (pos_q == PosW'(PktLen - 1));
        empty_q <= 1'b0;
        wait_q  <= !q_empty;
        pos_q   <= pos_q + 1'b1;
      end
    end
  end

  assign out_full_o        = full_q;
  assign dest_o            = dest_q;
  assign out_byte_o        = obyte_q;
  assign last_of_run_o     = lastr_q;
  assign read_empty_o      = empty_q;
  assign packets_waiting_o = wait_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && !out_ready_i |=> full_q)
    else $error("result lost while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qwe |-> copy_q)
    else $error("queue write outside copy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("bad receive phase");
endmodule
`default_nettype wire

### hdl/crc_packet_link_receiver.sv
// CRC packet link receiver: a request that gives at most one byte passes IDLE and EXEC;
// a burst emits 18 bytes, after a CRC build for ack or retransmit.
// Next request is taken after the last byte enters the output register; stalls hold the emit.
// Reset (rst_ni low, asynchronous) restores registers to defaults, empties the queue
// and zeroes the last-sent packet. Depends on cplr_pkg, cplr_ctrl and cplr_dp.
`default_nettype none
module crc_packet_link_receiver import cplr_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [1:0] cfg_idx_i,
  input  wire  [7:0] cfg_data_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [1:0] cmd_i,
  input  wire  [7:0] data_byte_i,
  input  wire        host_last_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic       dest_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       read_empty_o,
  output logic       packets_waiting_o
);
  ctl_t ctl;
  sts_t sts;
  logic full;

  cplr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_ready_i,
    .out_full_i(full), .sts_i(sts), .ctl_o(ctl)
  );

  cplr_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i, .data_byte_i, .host_last_i, .ctl_i(ctl), .sts_o(sts),
    .out_full_o(full), .out_ready_i, .dest_o, .out_byte_o, .last_of_run_o,
    .read_empty_o, .packets_waiting_o
  );

  assign out_valid_o = full;
endmodule
`default_nettype wire
